### hdl/apt_pkg.sv
// Shared constants for the averaged proximity phase trigger.
package apt_pkg;
   localparam int WINDOW    = 100;
   localparam int COORD_W   = 20;
   localparam int AXIS_W    = 16;
   localparam int LIMIT_W   = 16;
   localparam int SLOT_W    = $clog2(WINDOW);
   localparam int FILL_W    = $clog2(WINDOW + 1);
   localparam int SUM_W     = COORD_W + $clog2(WINDOW);
   localparam int DIV_W     = SUM_W + 2;
   localparam int REM_W     = $clog2(WINDOW) + 1;
   localparam int AVG_W     = COORD_W + 1;
   localparam int PROD_W    = AVG_W + AXIS_W;
   localparam int ERR_W     = COORD_W + 4;
   localparam int MAG_W     = ERR_W - 1;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int D2_W      = SQ_W + 2;
   localparam int CNT_W     = $clog2(DIV_W);
   localparam int ENTRY_W   = 3 * COORD_W;
   localparam int FRAC_W    = 14;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Z   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 3'd6;

   localparam logic [1:0] PHASE_RIGHT = 2'd0;
   localparam logic [1:0] PHASE_LEFT  = 2'd1;

   typedef logic signed [SUM_W-1:0] sum_type;
endpackage

### hdl/averaged_proximity_phase_trigger_core.sv
// Averaged proximity phase trigger: sliding window average and bit-serial tube distance check.
// One word is taken at a time; the next is accepted the cycle after the result is registered.
// A frame in the final phase goes straight to the output step, and one that leaves the window
// short of full passes through the window update step first. A frame that fills the window
// runs a bit-serial chain: the window update step, a divide by the window size (three
// coordinates in parallel), a shift-add projection over the 16 axis bits, an error step, a
// shift-add squaring over 23 magnitude bits, a compare step and an output step. A result
// that waits on rsp_ready holds the block in its output step and stalls the input.
// The sample ring is a one-port memory of WINDOW entries and needs no clearing.
module averaged_proximity_phase_trigger_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [apt_pkg::COORD_W-1:0]     req_right_x,
   input  logic signed [apt_pkg::COORD_W-1:0]     req_right_y,
   input  logic signed [apt_pkg::COORD_W-1:0]     req_right_z,
   input  logic signed [apt_pkg::COORD_W-1:0]     req_left_x,
   input  logic signed [apt_pkg::COORD_W-1:0]     req_left_y,
   input  logic signed [apt_pkg::COORD_W-1:0]     req_left_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_current_phase,
   output logic                                   rsp_advanced,
   output logic                                   rsp_window_full,
   input  logic                                   csr_we,
   input  logic [apt_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [apt_pkg::COORD_W-1:0]            csr_wdata
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UPD  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_ERR  = 3'd4;
   localparam logic [2:0] S_SQR  = 3'd5;
   localparam logic [2:0] S_CMP  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   localparam logic [apt_pkg::DIV_W-1:0] DIV_BIAS =
      apt_pkg::DIV_W'(apt_pkg::WINDOW * (1 << apt_pkg::COORD_W) + apt_pkg::WINDOW / 2);
   localparam logic [apt_pkg::DIV_W-1:0] AVG_BIAS = apt_pkg::DIV_W'(1 << apt_pkg::COORD_W);
   localparam logic [apt_pkg::PROD_W-1:0] ROUND_HALF =
      apt_pkg::PROD_W'(1 << (apt_pkg::FRAC_W - 1));
   localparam logic [apt_pkg::REM_W:0] DIVISOR = (apt_pkg::REM_W + 1)'(apt_pkg::WINDOW);
   localparam logic [apt_pkg::FILL_W-1:0] FILL_MAX = apt_pkg::FILL_W'(apt_pkg::WINDOW);
   localparam logic [apt_pkg::SLOT_W-1:0] SLOT_LAST = apt_pkg::SLOT_W'(apt_pkg::WINDOW - 1);
   localparam logic [apt_pkg::CNT_W-1:0] DIV_LAST = apt_pkg::CNT_W'(apt_pkg::DIV_W - 1);
   localparam logic [apt_pkg::CNT_W-1:0] MUL_LAST = apt_pkg::CNT_W'(apt_pkg::AXIS_W - 1);
   localparam logic [apt_pkg::CNT_W-1:0] SQR_LAST = apt_pkg::CNT_W'(apt_pkg::MAG_W - 1);

   logic [2:0]                              state_ff, state_in;
   logic [1:0]                              phase_ff, phase_in;
   logic [apt_pkg::FILL_W-1:0]              fill_ff, fill_in;
   logic [apt_pkg::SLOT_W-1:0]              slot_ff, slot_in;
   apt_pkg::sum_type                        sum_ff [3];
   apt_pkg::sum_type                        sum_in [3];
   logic [apt_pkg::CNT_W-1:0]               cnt_ff, cnt_in;

   logic signed [apt_pkg::COORD_W-1:0]      center_ff [3];
   logic signed [apt_pkg::AXIS_W-1:0]       axis_ff [3];
   logic [apt_pkg::LIMIT_W-1:0]             limit_ff;

   logic [apt_pkg::ENTRY_W-1:0]             ring [apt_pkg::WINDOW];
   logic [apt_pkg::ENTRY_W-1:0]             rd_data_ff;
   logic                                    ring_we;

   logic signed [apt_pkg::COORD_W-1:0]      pos_ff [3];
   logic [apt_pkg::DIV_W-1:0]               dvd_ff [3];
   logic [apt_pkg::DIV_W-1:0]               dvd_in [3];
   logic [apt_pkg::REM_W-1:0]               rem_ff [3];
   logic [apt_pkg::REM_W-1:0]               rem_in [3];
   logic signed [apt_pkg::AVG_W-1:0]        avg_ff [3];
   logic signed [apt_pkg::AVG_W-1:0]        avg_in [3];
   logic [apt_pkg::PROD_W-1:0]              mcand_ff, mcand_in;
   logic [apt_pkg::AXIS_W-1:0]              mbits_ff [3];
   logic [apt_pkg::AXIS_W-1:0]              mbits_in [3];
   logic [apt_pkg::PROD_W-1:0]              acc_ff [3];
   logic [apt_pkg::PROD_W-1:0]              acc_in [3];
   logic [apt_pkg::SQ_W-1:0]                sq_ff [3];
   logic [apt_pkg::SQ_W-1:0]                sq_in [3];
   logic [apt_pkg::MAG_W-1:0]               mag_ff [3];
   logic [apt_pkg::MAG_W-1:0]               mag_in [3];
   logic [apt_pkg::D2_W-1:0]                d2_ff, d2_in;

   logic                                    res_adv_ff, res_adv_in;
   logic                                    res_full_ff, res_full_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]                              rsp_phase_ff, rsp_phase_in;
   logic                                    rsp_adv_ff, rsp_adv_in;
   logic                                    rsp_full_ff, rsp_full_in;

   logic                                    accept;
   logic [apt_pkg::REM_W:0]                 trial [3];
   logic signed [apt_pkg::PROD_W-1:0]       proj [3];
   logic signed [apt_pkg::ERR_W-1:0]        err [3];
   logic [apt_pkg::D2_W-1:0]                d2_add;
   logic [2*apt_pkg::LIMIT_W-1:0]           lim2;

   assign req_ready         = (state_ff == S_IDLE);
   assign accept            = req_valid && req_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_phase = rsp_phase_ff;
   assign rsp_advanced      = rsp_adv_ff;
   assign rsp_window_full   = rsp_full_ff;
   assign ring_we           = (state_ff == S_UPD);
   assign lim2              = limit_ff * limit_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      mcand_in     = mcand_ff;
      d2_in        = d2_ff;
      d2_add       = '0;
      res_adv_in   = res_adv_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_phase_in = rsp_phase_ff;
      rsp_adv_in   = rsp_adv_ff;
      rsp_full_in  = rsp_full_ff;
      for (int k = 0; k < 3; k++) begin
         sum_in[k]   = sum_ff[k];
         dvd_in[k]   = dvd_ff[k];
         rem_in[k]   = rem_ff[k];
         avg_in[k]   = avg_ff[k];
         mbits_in[k] = mbits_ff[k];
         acc_in[k]   = acc_ff[k];
         sq_in[k]    = sq_ff[k];
         mag_in[k]   = mag_ff[k];
         trial[k]    = {rem_ff[k], dvd_ff[k][apt_pkg::DIV_W-1]};
         proj[k]     = $signed(acc_ff[k] + ROUND_HALF) >>> apt_pkg::FRAC_W;
         err[k]      = apt_pkg::ERR_W'(avg_ff[k]) - apt_pkg::ERR_W'(center_ff[k])
                       - apt_pkg::ERR_W'(proj[k]);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_adv_in  = 1'b0;
               res_full_in = 1'b0;
               if (phase_ff == apt_pkg::PHASE_RIGHT || phase_ff == apt_pkg::PHASE_LEFT) begin
                  state_in = S_UPD;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_UPD: begin
            for (int k = 0; k < 3; k++) begin
               sum_in[k] = sum_ff[k] + apt_pkg::SUM_W'(pos_ff[k]);
               if (fill_ff == FILL_MAX) begin
                  sum_in[k] = sum_in[k] - apt_pkg::SUM_W'($signed(
                     rd_data_ff[k*apt_pkg::COORD_W +: apt_pkg::COORD_W]));
               end
               dvd_in[k] = apt_pkg::DIV_W'(sum_in[k]) + DIV_BIAS;
               rem_in[k] = '0;
            end
            slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
            if (fill_ff != FILL_MAX) begin
               fill_in = fill_ff + 1'b1;
            end
            cnt_in = '0;
            if (fill_in == FILL_MAX) begin
               res_full_in = 1'b1;
               state_in    = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            for (int k = 0; k < 3; k++) begin
               if (trial[k] >= DIVISOR) begin
                  rem_in[k] = apt_pkg::REM_W'(trial[k] - DIVISOR);
                  dvd_in[k] = {dvd_ff[k][apt_pkg::DIV_W-2:0], 1'b1};
               end else begin
                  rem_in[k] = trial[k][apt_pkg::REM_W-1:0];
                  dvd_in[k] = {dvd_ff[k][apt_pkg::DIV_W-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               for (int k = 0; k < 3; k++) begin
                  avg_in[k]   = apt_pkg::AVG_W'(dvd_in[k] - AVG_BIAS);
                  mbits_in[k] = axis_ff[k];
                  acc_in[k]   = '0;
               end
               mcand_in = apt_pkg::PROD_W'($signed(avg_in[1] - apt_pkg::AVG_W'(center_ff[1])));
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            for (int k = 0; k < 3; k++) begin
               if (mbits_ff[k][0]) begin
                  acc_in[k] = (cnt_ff == MUL_LAST) ? acc_ff[k] - mcand_ff
                                                   : acc_ff[k] + mcand_ff;
               end
               mbits_in[k] = mbits_ff[k] >> 1;
            end
            mcand_in = mcand_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            for (int k = 0; k < 3; k++) begin
               mag_in[k] = err[k][apt_pkg::ERR_W-1] ? apt_pkg::MAG_W'(-err[k])
                                                    : apt_pkg::MAG_W'(err[k]);
               sq_in[k]  = apt_pkg::SQ_W'(mag_in[k]);
            end
            d2_in    = '0;
            cnt_in   = '0;
            state_in = S_SQR;
         end
         S_SQR: begin
            for (int k = 0; k < 3; k++) begin
               if (mag_ff[k][0]) begin
                  d2_add = d2_add + apt_pkg::D2_W'(sq_ff[k]);
               end
               mag_in[k] = mag_ff[k] >> 1;
               sq_in[k]  = sq_ff[k] << 1;
            end
            d2_in  = d2_ff + d2_add;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQR_LAST) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (d2_ff <= apt_pkg::D2_W'(lim2)) begin
               res_adv_in = 1'b1;
               phase_in   = phase_ff + 1'b1;
               fill_in    = '0;
               slot_in    = '0;
               for (int k = 0; k < 3; k++) begin
                  sum_in[k] = '0;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = phase_ff;
               rsp_adv_in   = res_adv_ff;
               rsp_full_in  = res_full_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= apt_pkg::PHASE_RIGHT;
         fill_ff      <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= apt_pkg::LIMIT_W'(500);
         for (int k = 0; k < 3; k++) begin
            sum_ff[k]    <= '0;
            center_ff[k] <= '0;
            axis_ff[k]   <= (k == 1) ? apt_pkg::AXIS_W'(1 << apt_pkg::FRAC_W) : '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= sum_in[k];
         end
         if (csr_we) begin
            unique case (csr_index)
               apt_pkg::CSR_CENTER_X: center_ff[0] <= csr_wdata;
               apt_pkg::CSR_CENTER_Y: center_ff[1] <= csr_wdata;
               apt_pkg::CSR_CENTER_Z: center_ff[2] <= csr_wdata;
               apt_pkg::CSR_AXIS_X:   axis_ff[0]   <= csr_wdata[apt_pkg::AXIS_W-1:0];
               apt_pkg::CSR_AXIS_Y:   axis_ff[1]   <= csr_wdata[apt_pkg::AXIS_W-1:0];
               apt_pkg::CSR_AXIS_Z:   axis_ff[2]   <= csr_wdata[apt_pkg::AXIS_W-1:0];
               apt_pkg::CSR_LIMIT:    limit_ff     <= csr_wdata[apt_pkg::LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      mcand_ff     <= mcand_in;
      d2_ff        <= d2_in;
      res_adv_ff   <= res_adv_in;
      res_full_ff  <= res_full_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_adv_ff   <= rsp_adv_in;
      rsp_full_ff  <= rsp_full_in;
      for (int k = 0; k < 3; k++) begin
         dvd_ff[k]   <= dvd_in[k];
         rem_ff[k]   <= rem_in[k];
         avg_ff[k]   <= avg_in[k];
         mbits_ff[k] <= mbits_in[k];
         acc_ff[k]   <= acc_in[k];
         sq_ff[k]    <= sq_in[k];
         mag_ff[k]   <= mag_in[k];
      end
      if (accept) begin
         rd_data_ff <= ring[slot_ff];
         if (phase_ff == apt_pkg::PHASE_RIGHT) begin
            pos_ff[0] <= req_right_x;
            pos_ff[1] <= req_right_y;
            pos_ff[2] <= req_right_z;
         end else begin
            pos_ff[0] <= req_left_x;
            pos_ff[1] <= req_left_y;
            pos_ff[2] <= req_left_z;
         end
      end
      if (ring_we) begin
         ring[slot_ff] <= {pos_ff[2], pos_ff[1], pos_ff[0]};
      end
   end
endmodule

### tb/tb_top.sv
// Self-checking testbench for averaged_proximity_phase_trigger_core.
module tb_top;
   localparam int EXP_DEPTH = 16;
   localparam logic [apt_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic signed [apt_pkg::COORD_W-1:0] rx, ry, rz, lx, ly, lz;
   } frame_type;

   typedef struct {
      logic [1:0] phase;
      logic       adv;
      logic       full;
   } verdict_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [apt_pkg::COORD_W-1:0]   req_right_x, req_right_y, req_right_z;
   logic signed [apt_pkg::COORD_W-1:0]   req_left_x, req_left_y, req_left_z;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [1:0]                           rsp_current_phase;
   logic                                 rsp_advanced;
   logic                                 rsp_window_full;
   logic                                 csr_we;
   logic [apt_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [apt_pkg::COORD_W-1:0]          csr_wdata;

   averaged_proximity_phase_trigger_core uut (.*);

   // tracked copy of the block
   logic [1:0] trk_phase;
   int         ring[apt_pkg::WINDOW][3];
   int         fill_cnt, slot;
   longint     acc[3];
   longint     center[3], axis[3], limit;

   verdict_type exp_q[EXP_DEPTH];
   int          exp_head = 0;
   int          exp_tail = 0;
   int          errors, frames, fulls, advances;
   int          burst_left, hold_cycles;
   bit          gaps_on;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return q;
   endfunction

   function automatic verdict_type track_frame(frame_type f);
      verdict_type v;
      longint   pos[3];
      longint   avg[3];
      longint   yoff, p, e, d2;
      v.adv = 0;
      v.full = 0;
      if (trk_phase <= 1) begin
         if (trk_phase == apt_pkg::PHASE_RIGHT) begin
            pos[0] = f.rx; pos[1] = f.ry; pos[2] = f.rz;
         end else begin
            pos[0] = f.lx; pos[1] = f.ly; pos[2] = f.lz;
         end
         if (slot >= apt_pkg::WINDOW) slot = 0;
         for (int k = 0; k < 3; k++) begin
            if (fill_cnt >= apt_pkg::WINDOW) acc[k] -= ring[slot][k];
            ring[slot][k] = int'(pos[k]);
            acc[k] += pos[k];
         end
         slot = (slot + 1 >= apt_pkg::WINDOW) ? 0 : slot + 1;
         if (fill_cnt < apt_pkg::WINDOW) fill_cnt++;
         if (fill_cnt == apt_pkg::WINDOW) begin
            v.full = 1;
            for (int k = 0; k < 3; k++)
               avg[k] = floor_div(acc[k] + apt_pkg::WINDOW / 2, apt_pkg::WINDOW);
            yoff = avg[1] - center[1];
            d2 = 0;
            for (int k = 0; k < 3; k++) begin
               p = floor_div(yoff * axis[k] + 8192, 16384);
               e = avg[k] - center[k] - p;
               d2 += e * e;
            end
            if (d2 <= limit * limit) begin
               v.adv = 1;
               trk_phase++;
               fill_cnt = 0;
               slot = 0;
               acc = '{0, 0, 0};
            end
         end
      end
      v.phase = trk_phase;
      return v;
   endfunction

   // mostly in range, now and then any 20-bit value
   function automatic logic signed [apt_pkg::COORD_W-1:0] any_coord();
      if ($urandom_range(0, 15) == 0) return apt_pkg::COORD_W'($urandom);
      return apt_pkg::COORD_W'(int'($urandom_range(0, 1000000)) - 500000);
   endfunction

   function automatic frame_type rand_frame();
      frame_type f;
      f.rx = any_coord(); f.ry = any_coord(); f.rz = any_coord();
      f.lx = any_coord(); f.ly = any_coord(); f.lz = any_coord();
      return f;
   endfunction

   // point close to the tube line, same point on both hands
   function automatic frame_type tube_frame(int noise);
      frame_type f;
      longint yrel;
      longint c[3];
      yrel = longint'($urandom_range(0, 2000)) - 1000;
      for (int k = 0; k < 3; k++)
         c[k] = center[k] + floor_div(yrel * axis[k] + 8192, 16384)
                + longint'($urandom_range(0, 2 * noise)) - noise;
      f.rx = apt_pkg::COORD_W'(c[0]); f.ry = apt_pkg::COORD_W'(c[1]);
      f.rz = apt_pkg::COORD_W'(c[2]);
      f.lx = apt_pkg::COORD_W'(c[0]); f.ly = apt_pkg::COORD_W'(c[1]);
      f.lz = apt_pkg::COORD_W'(c[2]);
      return f;
   endfunction

   task automatic write_csr(logic [apt_pkg::CSR_IDX_W-1:0] idx, longint value);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = apt_pkg::COORD_W'(value);
      @(posedge clock);
      case (idx)
         apt_pkg::CSR_CENTER_X: center[0] = longint'($signed(csr_wdata));
         apt_pkg::CSR_CENTER_Y: center[1] = longint'($signed(csr_wdata));
         apt_pkg::CSR_CENTER_Z: center[2] = longint'($signed(csr_wdata));
         apt_pkg::CSR_AXIS_X:
            axis[0] = longint'($signed(csr_wdata[apt_pkg::AXIS_W-1:0]));
         apt_pkg::CSR_AXIS_Y:
            axis[1] = longint'($signed(csr_wdata[apt_pkg::AXIS_W-1:0]));
         apt_pkg::CSR_AXIS_Z:
            axis[2] = longint'($signed(csr_wdata[apt_pkg::AXIS_W-1:0]));
         apt_pkg::CSR_LIMIT:    limit = longint'(csr_wdata[apt_pkg::LIMIT_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic set_tube(longint cx, cy, cz, ax, ay, az, lim);
      write_csr(apt_pkg::CSR_CENTER_X, cx);
      write_csr(apt_pkg::CSR_CENTER_Y, cy);
      write_csr(apt_pkg::CSR_CENTER_Z, cz);
      write_csr(apt_pkg::CSR_AXIS_X, ax);
      write_csr(apt_pkg::CSR_AXIS_Y, ay);
      write_csr(apt_pkg::CSR_AXIS_Z, az);
      write_csr(apt_pkg::CSR_LIMIT, lim);
   endtask

   task automatic offer(frame_type f, bit typed, verdict_type tv);
      verdict_type v;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 24));
         if (gaps_on) begin
            req_valid = 0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1;
      req_right_x = f.rx; req_right_y = f.ry; req_right_z = f.rz;
      req_left_x = f.lx;  req_left_y = f.ly;  req_left_z = f.lz;
      do @(posedge clock); while (!req_ready);
      v = track_frame(f);
      if (v.full) fulls++;
      if (v.adv) advances++;
      exp_q[exp_tail % EXP_DEPTH] = typed ? tv : v;
      exp_tail++;
      frames++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 0;
      wait (exp_tail == exp_head);
      @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_run(int count);
      verdict_type none;
      none = '{default: 0};
      gaps_on = $urandom_range(0, 3) != 0;
      repeat (count) offer(rand_frame(), 0, none);
   endtask

   task automatic reach_run(int noise);
      verdict_type none;
      logic [1:0] start;
      none = '{default: 0};
      start = trk_phase;
      for (int n = 0; n < 300 && trk_phase == start; n++) offer(tube_frame(noise), 0, none);
      repeat (10) offer(tube_frame(noise), 0, none);
   endtask

   // receiver: stall pattern plus an optional long hold
   initial begin
      int  span;
      bit  stalling;
      rsp_ready = 0;
      span = 0;
      stalling = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            span = int'($urandom_range(50, 400));
            stalling = $urandom_range(0, 1);
         end
         span--;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready = 0;
         end else begin
            rsp_ready = stalling ? ($urandom_range(0, 2) != 0) : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      verdict_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_tail == exp_head) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            w = exp_q[exp_head % EXP_DEPTH];
            exp_head++;
            if (rsp_current_phase !== w.phase) begin
               $error("current_phase expected %0d got %0d", w.phase, rsp_current_phase);
               errors++;
            end
            if (rsp_advanced !== w.adv) begin
               $error("advanced expected %0d got %0d", w.adv, rsp_advanced);
               errors++;
            end
            if (rsp_window_full !== w.full) begin
               $error("window_full expected %0d got %0d", w.full, rsp_window_full);
               errors++;
            end
         end
      end
   end

   initial begin
      int          ext[10];
      frame_type   f;
      verdict_type idle_v;
      ext = '{500000, -500000, 0, -1, 1, 349525, -349526, 524287, -524288, 131071};
      reset = 1;
      req_valid = 0;
      req_right_x = 0; req_right_y = 0; req_right_z = 0;
      req_left_x = 0;  req_left_y = 0;  req_left_z = 0;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      errors = 0; frames = 0; fulls = 0; advances = 0;
      burst_left = 0; hold_cycles = 0; gaps_on = 1;
      trk_phase = apt_pkg::PHASE_RIGHT; fill_cnt = 0; slot = 0; acc = '{0, 0, 0};
      center = '{0, 0, 0}; axis = '{0, 16384, 0}; limit = 500;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // window still filling: nothing averaged yet
      idle_v = '{phase: apt_pkg::PHASE_RIGHT, adv: 1'b0, full: 1'b0};
      for (int i = 0; i < 25; i++) begin
         f.rx = apt_pkg::COORD_W'(ext[i % 10]);
         f.ry = apt_pkg::COORD_W'(ext[(i + 3) % 10]);
         f.rz = apt_pkg::COORD_W'(ext[(i + 7) % 10]);
         f.lx = apt_pkg::COORD_W'(ext[(i + 1) % 10]);
         f.ly = apt_pkg::COORD_W'(ext[(i + 5) % 10]);
         f.lz = apt_pkg::COORD_W'(ext[(i + 9) % 10]);
         offer(f, 1, idle_v);
      end
      drain();

      // right hand, far from the tube, several settings
      set_tube(500000, -500000, 500000, 16384, -16384, 16384, 65535);
      hold_cycles = 400;
      random_run(250);
      drain();
      set_tube(-500000, 500000, -500000, 32767, -32768, 0, 0);
      write_csr(CSR_UNUSED, 20'hFFFFF);
      random_run(250);
      drain();
      set_tube(400000, $urandom_range(0, 200000), -400000,
               $urandom_range(0, 8000), $urandom_range(0, 16384), $urandom_range(0, 8000),
               $urandom_range(0, 1000));
      random_run(250);
      drain();

      // bring the right hand onto a vertical tube
      set_tube(1000, -2000, 3000, 0, 16384, 0, 40);
      reach_run(15);
      drain();

      // left hand, far from the tube
      set_tube(-450000, 100000, 450000, -16384, 16384, -16384, 65535);
      hold_cycles = 300;
      random_run(250);
      drain();
      set_tube(480000, -300000, -480000, 0, 0, 16384, 0);
      random_run(250);
      drain();

      // bring the left hand onto a tilted tube
      set_tube(-12000, 5000, 7000, 6000, 15000, -4000, 60);
      reach_run(20);
      drain();

      // final phase ignores frames
      random_run(60);
      drain();

      $display("Ran %0d frames: %0d full-window averages, %0d phase advances,",
               frames, fulls, advances);
      $display("ending in phase %0d across eight register settings.", trk_phase);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
